FILE: rtl/core/csync_pkg.sv
// Package for the composite sync separator: class codes, phase and standard
// enums, configuration register map and the configuration struct.
// No dependencies.
package csync_pkg;

    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_PRE  = 2'd1,
        PH_SERR = 2'd2,
        PH_POST = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        PU_UNKNOWN = 3'd0,
        PU_OUT     = 3'd1,
        PU_HSYNC   = 3'd2,
        PU_EQU     = 3'd3,
        PU_BROAD   = 3'd4
    } t_pulse;

    typedef enum logic [1:0] {
        PE_UNKNOWN = 2'd0,
        PE_OUT     = 2'd1,
        PE_FULL    = 2'd2,
        PE_HALF    = 2'd3
    } t_period;

    typedef enum logic [1:0] {
        STD_UNKNOWN = 2'd0,
        STD_PAL     = 2'd1,
        STD_NTSC    = 2'd2
    } t_std;

    typedef enum logic [IDX_W-1:0] {
        REG_LINE_CLKS  = 3'd0,
        REG_LINE_TOL   = 3'd1,
        REG_EQU_CLKS   = 3'd2,
        REG_EQU_TOL    = 3'd3,
        REG_HSYNC_CLKS = 3'd4,
        REG_HSYNC_TOL  = 3'd5,
        REG_BROAD_CLKS = 3'd6,
        REG_BROAD_TOL  = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_LINE_CLKS  = 16'd5376;
    localparam logic [CFG_W-1:0] RST_LINE_TOL   = 16'd42;
    localparam logic [CFG_W-1:0] RST_EQU_CLKS   = 16'd197;
    localparam logic [CFG_W-1:0] RST_EQU_TOL    = 16'd21;
    localparam logic [CFG_W-1:0] RST_HSYNC_CLKS = 16'd395;
    localparam logic [CFG_W-1:0] RST_HSYNC_TOL  = 16'd21;
    localparam logic [CFG_W-1:0] RST_BROAD_CLKS = 16'd2293;
    localparam logic [CFG_W-1:0] RST_BROAD_TOL  = 16'd42;

    typedef struct packed {
        logic [CFG_W-1:0] line_clks;
        logic [CFG_W-1:0] line_tol;
        logic [CFG_W-1:0] equ_clks;
        logic [CFG_W-1:0] equ_tol;
        logic [CFG_W-1:0] hsync_clks;
        logic [CFG_W-1:0] hsync_tol;
        logic [CFG_W-1:0] broad_clks;
        logic [CFG_W-1:0] broad_tol;
    } t_cfg;

    typedef struct packed {
        t_pulse  pulse;
        t_period period;
    } t_class;

endpackage

FILE: rtl/core/csync_classify.sv
// Classifier for one measured interval: period class (half/full line) and
// pulse class (equalising/broad/hsync). Depends on csync_pkg.
module csync_classify #(
    parameter int TIME_WIDTH = 16
) (
    input  logic [TIME_WIDTH-1:0] i_delta,
    input  csync_pkg::t_cfg       i_cfg,
    output csync_pkg::t_class     o_class
);
    import csync_pkg::*;

    localparam int SUM_W = CFG_W + 1;
    localparam int CMP_W = (TIME_WIDTH > SUM_W) ? TIME_WIDTH : SUM_W;

    logic [CMP_W-1:0] w_d;
    logic [SUM_W-1:0] w_line_hi;
    logic [CFG_W-1:0] w_line_lo;
    logic [CFG_W-1:0] w_half_hi;
    logic [CFG_W-1:0] w_half_lo;
    logic [SUM_W-1:0] w_equ_hi;
    logic [CFG_W-1:0] w_equ_lo;
    logic [SUM_W-1:0] w_hs_hi;
    logic [CFG_W-1:0] w_hs_lo;
    logic [SUM_W-1:0] w_br_hi;
    logic [CFG_W-1:0] w_br_lo;

    function automatic logic [CFG_W-1:0] sat_sub(input logic [CFG_W-1:0] a,
                                                 input logic [CFG_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    always_comb begin
        w_d       = CMP_W'(i_delta);
        w_line_hi = SUM_W'(i_cfg.line_clks) + SUM_W'(i_cfg.line_tol);
        w_line_lo = sat_sub(i_cfg.line_clks, i_cfg.line_tol);
        w_half_hi = w_line_hi[SUM_W-1:1];
        w_half_lo = w_line_lo >> 1;
        w_equ_hi  = SUM_W'(i_cfg.equ_clks) + SUM_W'(i_cfg.equ_tol);
        w_equ_lo  = sat_sub(i_cfg.equ_clks, i_cfg.equ_tol);
        w_hs_hi   = SUM_W'(i_cfg.hsync_clks) + SUM_W'(i_cfg.hsync_tol);
        w_hs_lo   = sat_sub(i_cfg.hsync_clks, i_cfg.hsync_tol);
        w_br_hi   = SUM_W'(i_cfg.broad_clks) + SUM_W'(i_cfg.broad_tol);
        w_br_lo   = sat_sub(i_cfg.broad_clks, i_cfg.broad_tol);

        if (w_d <= CMP_W'(w_half_hi)) begin
            o_class.period = (w_d >= CMP_W'(w_half_lo)) ? PE_HALF : PE_OUT;
        end else if (w_d >= CMP_W'(w_line_lo) && w_d <= CMP_W'(w_line_hi)) begin
            o_class.period = PE_FULL;
        end else begin
            o_class.period = PE_OUT;
        end

        if (w_d <= CMP_W'(w_equ_hi)) begin
            o_class.pulse = (w_d >= CMP_W'(w_equ_lo)) ? PU_EQU : PU_OUT;
        end else if (w_d >= CMP_W'(w_br_lo)) begin
            o_class.pulse = (w_d <= CMP_W'(w_br_hi)) ? PU_BROAD : PU_OUT;
        end else if (w_d >= CMP_W'(w_hs_lo) && w_d <= CMP_W'(w_hs_hi)) begin
            o_class.pulse = PU_HSYNC;
        end else begin
            o_class.pulse = PU_OUT;
        end
    end

endmodule

FILE: rtl/core/composite_sync_separator.sv
// Composite sync separator top level: edge stream in, frame/class status out.
// Input transactions pass through the input reg, then the result reg.
// Throughput one edge per cycle unless m_axis_tready stalls the output.
// Reset (i_rst_n low, synchronous) clears the phase machine and standards and
// loads the nominal timing registers. Depends on csync_pkg, csync_classify.
module composite_sync_separator #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] capture_time
    input  logic                          s_axis_tuser,   // [0] action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] frame_start, [2:1] video_standard, [5:3] pulse_class,
    // [7:6] period_class, [9:8] sync_phase, [15:10] zero
    output logic [15:0]                   m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [csync_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [csync_pkg::CFG_W-1:0]   i_cfg_data
);
    import csync_pkg::*;

    localparam int EXT_W = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic                  r_in_action;
    logic [TIME_WIDTH-1:0] r_in_time;
    logic                  r_out_valid;
    logic [15:0]           r_out_data;

    logic                  r_edge_seen, n_edge_seen;
    logic [TIME_WIDTH-1:0] r_last_time, n_last_time;
    t_phase                r_phase, n_phase;
    logic [2:0]            r_count, n_count;
    t_pulse                r_last_pulse, n_last_pulse;
    t_period               r_last_period, n_last_period;
    t_std                  r_det_std, n_det_std;
    t_std                  r_pub_std, n_pub_std;
    logic                  n_frame;

    logic                  w_out_adv;
    logic                  w_proc;
    logic                  w_s_fire;
    logic [EXT_W-1:0]      w_time_ext;
    logic [TIME_WIDTH-1:0] w_delta;
    t_class                w_class;
    logic                  w_restart;
    logic                  w_half;
    logic [2:0]            w_inc;
    logic [2:0]            w_hs_lo;

    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_out_adv;
    assign s_axis_tready = !r_in_valid || w_out_adv;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_time_ext = EXT_W'(s_axis_tdata);
    assign w_delta    = r_in_time - r_last_time;

    csync_classify #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_classify (
        .i_delta(w_delta),
        .i_cfg  (r_cfg),
        .o_class(w_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_clks  <= RST_LINE_CLKS;
            r_cfg.line_tol   <= RST_LINE_TOL;
            r_cfg.equ_clks   <= RST_EQU_CLKS;
            r_cfg.equ_tol    <= RST_EQU_TOL;
            r_cfg.hsync_clks <= RST_HSYNC_CLKS;
            r_cfg.hsync_tol  <= RST_HSYNC_TOL;
            r_cfg.broad_clks <= RST_BROAD_CLKS;
            r_cfg.broad_tol  <= RST_BROAD_TOL;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LINE_CLKS:  r_cfg.line_clks  <= i_cfg_data;
                REG_LINE_TOL:   r_cfg.line_tol   <= i_cfg_data;
                REG_EQU_CLKS:   r_cfg.equ_clks   <= i_cfg_data;
                REG_EQU_TOL:    r_cfg.equ_tol    <= i_cfg_data;
                REG_HSYNC_CLKS: r_cfg.hsync_clks <= i_cfg_data;
                REG_HSYNC_TOL:  r_cfg.hsync_tol  <= i_cfg_data;
                REG_BROAD_CLKS: r_cfg.broad_clks <= i_cfg_data;
                REG_BROAD_TOL:  r_cfg.broad_tol  <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= w_s_fire || (r_in_valid && !w_out_adv);
            r_out_valid <= w_proc || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in_action <= s_axis_tuser;
            r_in_time   <= w_time_ext[TIME_WIDTH-1:0];
        end
        if (w_proc) begin
            r_out_data <= {6'd0, n_phase, n_last_period, n_last_pulse, n_pub_std, n_frame};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_seen   <= 1'b0;
            r_last_time   <= '0;
            r_phase       <= PH_SEEK;
            r_count       <= 3'd0;
            r_last_pulse  <= PU_UNKNOWN;
            r_last_period <= PE_UNKNOWN;
            r_det_std     <= STD_UNKNOWN;
            r_pub_std     <= STD_UNKNOWN;
        end else if (w_proc) begin
            r_edge_seen   <= n_edge_seen;
            r_last_time   <= n_last_time;
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_last_pulse  <= n_last_pulse;
            r_last_period <= n_last_period;
            r_det_std     <= n_det_std;
            r_pub_std     <= n_pub_std;
        end
    end

    always_comb begin
        n_edge_seen   = r_edge_seen;
        n_last_time   = r_last_time;
        n_phase       = r_phase;
        n_count       = r_count;
        n_last_pulse  = r_last_pulse;
        n_last_period = r_last_period;
        n_det_std     = r_det_std;
        n_pub_std     = r_pub_std;
        n_frame       = 1'b0;
        w_restart     = 1'b0;
        w_half        = (w_class.period == PE_HALF);
        w_inc         = r_count + 3'd1;
        w_hs_lo       = (r_det_std == STD_NTSC) ? 3'd5 : 3'd4;

        if (!r_in_action) begin
            n_last_time = r_in_time;
            if (!r_edge_seen) begin
                n_edge_seen = 1'b1;
            end else begin
                n_last_period = w_class.period;
                if (w_class.period == PE_OUT) begin
                    w_restart = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_SEEK: begin
                            if (w_half && r_last_pulse == PU_EQU) begin
                                n_phase = PH_PRE;
                                n_count = 3'd1;
                            end else begin
                                w_restart = 1'b1;
                            end
                        end
                        PH_PRE: begin
                            if (w_half && r_last_pulse == PU_BROAD && r_count >= 3'd4) begin
                                n_phase = PH_SERR;
                                n_count = 3'd1;
                            end else if (w_half && r_last_pulse == PU_EQU && w_inc != 3'd7) begin
                                n_count = w_inc;
                            end else begin
                                w_restart = 1'b1;
                            end
                        end
                        PH_SERR: begin
                            if (w_half && r_last_pulse == PU_EQU
                                && (r_count == 3'd5 || r_count == 3'd6)) begin
                                n_det_std = (r_count == 3'd6) ? STD_NTSC : STD_PAL;
                                n_phase   = PH_POST;
                                n_count   = 3'd1;
                            end else if (w_half && r_last_pulse == PU_BROAD
                                         && w_inc != 3'd7) begin
                                n_count = w_inc;
                            end else begin
                                w_restart = 1'b1;
                            end
                        end
                        PH_POST: begin
                            if (r_last_pulse == PU_EQU
                                && ((r_det_std == STD_NTSC && w_inc != 3'd7)
                                    || (r_det_std == STD_PAL && w_inc < 3'd6))) begin
                                n_count = w_inc;
                            end else begin
                                w_restart = 1'b1;
                            end
                        end
                        default: w_restart = 1'b1;
                    endcase
                end
            end
        end else if (r_edge_seen) begin
            n_last_pulse = w_class.pulse;
            if (w_class.pulse == PU_OUT) begin
                w_restart = 1'b1;
            end else if (w_class.pulse == PU_HSYNC) begin
                if (r_phase != PH_POST) begin
                    w_restart = 1'b1;
                end else if (r_det_std == STD_NTSC || r_det_std == STD_PAL) begin
                    if (r_count == w_hs_lo || r_count == w_hs_lo + 3'd1) begin
                        n_frame   = 1'b1;
                        n_pub_std = r_det_std;
                    end
                    w_restart = 1'b1;
                end
            end
        end

        if (w_restart) begin
            n_edge_seen   = 1'b0;
            n_phase       = PH_SEEK;
            n_count       = 3'd0;
            n_last_pulse  = PU_UNKNOWN;
            n_last_period = PE_UNKNOWN;
        end
    end

`ifndef SYNTH
    a_frame_seeks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> (r_out_data[9:8] == PH_SEEK))
        else $error("frame result not followed by seeking");

    a_seek_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEEK) |-> (r_count == 3'd0))
        else $error("pulse count nonzero while seeking");

    a_track_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SEEK) |-> r_edge_seen)
        else $error("tracking without a stored edge");

    a_post_std: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_POST) |-> (r_det_std == STD_PAL || r_det_std == STD_NTSC))
        else $error("post-equalise without a detected standard");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for composite_sync_separator: sync edge stream in,
// per-edge status word out, compared against an in-bench tracker of the
// separator. Depends on csync_pkg and the composite_sync_separator RTL.
`timescale 1ns / 1ps

module testbench;
    import csync_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic EDGE_LEAD = 1'b0;
    localparam logic EDGE_TRAIL = 1'b1;

    typedef struct {
        logic        act;
        logic [15:0] stamp;
    } t_edge;

    typedef struct packed {
        logic [5:0] pad;
        t_phase     sync_ph;
        t_period    period_cls;
        t_pulse     pulse_cls;
        t_std       video_std;
        logic       frame_start;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    composite_sync_separator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tracker state
    t_cfg        cfg;
    logic        have_lead;
    logic [15:0] lead_time;
    t_phase      trk_phase;
    logic [2:0]  trk_count;
    t_pulse      trk_pulse;
    t_period     trk_period;
    t_std        std_found;
    t_std        std_shown;

    t_edge       edge_q[$];
    t_status     status_q[$];
    int          sent_n = 0;
    int          taken_n = 0;
    int          bad_n = 0;
    int unsigned cyc = 0;
    logic        in_fire = 1'b0;
    logic        calm = 1'b0;
    logic [15:0] tnow;
    int          spoil = 0;

    function automatic int floor0(int a, int b);
        return (a > b) ? (a - b) : 0;
    endfunction

    task automatic seek_again();
        have_lead = 1'b0;
        trk_phase = PH_SEEK;
        trk_count = 3'd0;
        trk_pulse = PU_UNKNOWN;
        trk_period = PE_UNKNOWN;
    endtask

    task automatic track_edge(input logic act, input logic [15:0] stamp, output t_status res);
        int          span;
        logic [2:0]  lo_cnt;
        int          lo_l, hi_l;
        logic        half, keep;
        res = '0;
        span = int'(16'(stamp - lead_time));
        if (act == EDGE_LEAD) begin
            if (!have_lead) begin
                lead_time = stamp;
                have_lead = 1'b1;
            end else begin
                lead_time = stamp;
                lo_l = floor0(int'(cfg.line_clks), int'(cfg.line_tol));
                hi_l = int'(cfg.line_clks) + int'(cfg.line_tol);
                if (span <= (hi_l >> 1))
                    trk_period = (span >= (lo_l >> 1)) ? PE_HALF : PE_OUT;
                else if (span >= lo_l && span <= hi_l)
                    trk_period = PE_FULL;
                else
                    trk_period = PE_OUT;
                half = (trk_period == PE_HALF);
                keep = 1'b0;
                if (trk_period != PE_OUT) begin
                    case (trk_phase)
                        PH_SEEK: begin
                            if (half && trk_pulse == PU_EQU) begin
                                trk_phase = PH_PRE;
                                trk_count = 3'd1;
                                keep = 1'b1;
                            end
                        end
                        PH_PRE: begin
                            if (half && trk_pulse == PU_BROAD && trk_count >= 3'd4) begin
                                trk_phase = PH_SERR;
                                trk_count = 3'd1;
                                keep = 1'b1;
                            end else if (half && trk_pulse == PU_EQU) begin
                                trk_count = trk_count + 3'd1;
                                keep = (trk_count < 3'd7);
                            end
                        end
                        PH_SERR: begin
                            if (half && trk_pulse == PU_EQU
                                    && (trk_count == 3'd5 || trk_count == 3'd6)) begin
                                std_found = (trk_count == 3'd6) ? STD_NTSC : STD_PAL;
                                trk_phase = PH_POST;
                                trk_count = 3'd1;
                                keep = 1'b1;
                            end else if (half && trk_pulse == PU_BROAD) begin
                                trk_count = trk_count + 3'd1;
                                keep = (trk_count < 3'd7);
                            end
                        end
                        default: begin
                            if (trk_pulse == PU_EQU) begin
                                trk_count = trk_count + 3'd1;
                                keep = (std_found == STD_NTSC && trk_count < 3'd7)
                                    || (std_found == STD_PAL && trk_count < 3'd6);
                            end
                        end
                    endcase
                end
                if (!keep) seek_again();
            end
        end else if (have_lead) begin
            if (span <= int'(cfg.equ_clks) + int'(cfg.equ_tol))
                trk_pulse = (span >= floor0(int'(cfg.equ_clks), int'(cfg.equ_tol)))
                    ? PU_EQU : PU_OUT;
            else if (span >= floor0(int'(cfg.broad_clks), int'(cfg.broad_tol)))
                trk_pulse = (span <= int'(cfg.broad_clks) + int'(cfg.broad_tol))
                    ? PU_BROAD : PU_OUT;
            else if (span >= floor0(int'(cfg.hsync_clks), int'(cfg.hsync_tol))
                    && span <= int'(cfg.hsync_clks) + int'(cfg.hsync_tol))
                trk_pulse = PU_HSYNC;
            else
                trk_pulse = PU_OUT;
            if (trk_pulse == PU_OUT) begin
                seek_again();
            end else if (trk_pulse == PU_HSYNC) begin
                if (trk_phase != PH_POST) begin
                    seek_again();
                end else if (std_found == STD_NTSC || std_found == STD_PAL) begin
                    lo_cnt = (std_found == STD_NTSC) ? 3'd5 : 3'd4;
                    if (trk_count == lo_cnt || trk_count == lo_cnt + 3'd1) begin
                        res.frame_start = 1'b1;
                        std_shown = std_found;
                    end
                    seek_again();
                end
            end
        end
        res.video_std = std_shown;
        res.pulse_cls = trk_pulse;
        res.period_cls = trk_period;
        res.sync_ph = trk_phase;
    endtask

    // sender
    always @(negedge i_clk) begin : drive
        t_edge nxt;
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (edge_q.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                nxt = edge_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= nxt.stamp;
                s_axis_tuser <= nxt.act;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin : check
        t_status got, want, nxt;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_status'(m_axis_tdata);
                if (status_q.size() == 0) begin
                    bad_n++;
                    if (bad_n <= 10)
                        $display("result %h with nothing pending", m_axis_tdata);
                end else begin
                    want = status_q.pop_front();
                    if (got.frame_start !== want.frame_start || got.video_std !== want.video_std
                            || got.pulse_cls !== want.pulse_cls
                            || got.period_cls !== want.period_cls
                            || got.sync_ph !== want.sync_ph || got.pad !== 6'd0) begin
                        bad_n++;
                        if (bad_n <= 10)
                            $display({"mismatch: frame %0d/%0d std %0d/%0d pulse %0d/%0d ",
                                      "period %0d/%0d phase %0d/%0d pad %0d (exp/act)"},
                                     want.frame_start, got.frame_start,
                                     want.video_std, got.video_std,
                                     want.pulse_cls, got.pulse_cls,
                                     want.period_cls, got.period_cls,
                                     want.sync_ph, got.sync_ph, got.pad);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LINE_CLKS:  cfg.line_clks = i_cfg_data;
                    REG_LINE_TOL:   cfg.line_tol = i_cfg_data;
                    REG_EQU_CLKS:   cfg.equ_clks = i_cfg_data;
                    REG_EQU_TOL:    cfg.equ_tol = i_cfg_data;
                    REG_HSYNC_CLKS: cfg.hsync_clks = i_cfg_data;
                    REG_HSYNC_TOL:  cfg.hsync_tol = i_cfg_data;
                    REG_BROAD_CLKS: cfg.broad_clks = i_cfg_data;
                    REG_BROAD_TOL:  cfg.broad_tol = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_edge(s_axis_tuser, s_axis_tdata, nxt);
                status_q.push_back(nxt);
                taken_n++;
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic put(input logic act, input logic [15:0] stamp);
        t_edge e;
        e.act = act;
        e.stamp = stamp;
        edge_q.push_back(e);
        sent_n++;
    endtask

    task automatic settle();
        while (taken_n != sent_n || status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_timing(input t_cfg v);
        write_reg(REG_LINE_CLKS, v.line_clks);
        write_reg(REG_LINE_TOL, v.line_tol);
        write_reg(REG_EQU_CLKS, v.equ_clks);
        write_reg(REG_EQU_TOL, v.equ_tol);
        write_reg(REG_HSYNC_CLKS, v.hsync_clks);
        write_reg(REG_HSYNC_TOL, v.hsync_tol);
        write_reg(REG_BROAD_CLKS, v.broad_clks);
        write_reg(REG_BROAD_TOL, v.broad_tol);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_in(int lo, int hi);
        return (hi > lo) ? lo + int'($urandom_range(hi - lo)) : lo;
    endfunction

    function automatic int near(int nom, int tol);
        return pick_in(floor0(nom, tol), nom + tol);
    endfunction

    function automatic int half_gap();
        return pick_in(floor0(int'(cfg.line_clks), int'(cfg.line_tol)) >> 1,
                       (int'(cfg.line_clks) + int'(cfg.line_tol)) >> 1);
    endfunction

    function automatic int full_gap();
        return near(int'(cfg.line_clks), int'(cfg.line_tol));
    endfunction

    task automatic add_pulse(input int w, input int gap);
        if ($urandom_range(99) < spoil) w = $urandom_range(65535);
        if ($urandom_range(99) < spoil) gap = $urandom_range(65535);
        put(EDGE_LEAD, tnow);
        if (!(spoil > 0 && $urandom_range(99) < 5))
            put(EDGE_TRAIL, tnow + 16'(w));
        tnow = tnow + 16'(gap);
    endtask

    // pre-equalising, serration, post-equalising trains, then hsync lines
    task automatic add_interval(input int spoil_pct);
        int n_pre, n_ser, n_post, ntsc;
        ntsc = $urandom_range(1);
        n_pre = 5 + ntsc;
        n_ser = 5 + ntsc;
        n_post = 5 + ntsc;
        if ($urandom_range(3) == 0) begin
            n_pre = $urandom_range(7, 3);
            n_ser = $urandom_range(7, 3);
            n_post = $urandom_range(7, 3);
        end
        spoil = spoil_pct;
        repeat (n_pre)
            add_pulse(near(int'(cfg.equ_clks), int'(cfg.equ_tol)), half_gap());
        repeat (n_ser)
            add_pulse(near(int'(cfg.broad_clks), int'(cfg.broad_tol)), half_gap());
        repeat (n_post)
            add_pulse(near(int'(cfg.equ_clks), int'(cfg.equ_tol)), half_gap());
        repeat ($urandom_range(3, 1))
            add_pulse(near(int'(cfg.hsync_clks), int'(cfg.hsync_tol)), full_gap());
        spoil = 0;
    endtask

    task automatic add_noise(input int n);
        int gap;
        repeat (n) begin
            case ($urandom_range(6))
                0: gap = $urandom_range(65535);
                1: gap = half_gap();
                2: gap = full_gap();
                3: gap = near(int'(cfg.equ_clks), int'(cfg.equ_tol));
                4: gap = near(int'(cfg.hsync_clks), int'(cfg.hsync_tol));
                5: gap = near(int'(cfg.broad_clks), int'(cfg.broad_tol));
                default: gap = 0;
            endcase
            tnow = tnow + 16'(gap);
            put(1'($urandom_range(1)), tnow);
        end
    endtask

    task automatic run_random(input int count);
        int goal, r;
        goal = sent_n + count;
        while (sent_n < goal) begin
            r = $urandom_range(99);
            if (r < 70)
                add_interval(0);
            else if (r < 85)
                add_interval(10);
            else
                add_noise($urandom_range(12, 4));
        end
    endtask

    initial begin
        t_cfg nominal;
        nominal = '{RST_LINE_CLKS, RST_LINE_TOL, RST_EQU_CLKS, RST_EQU_TOL,
                    RST_HSYNC_CLKS, RST_HSYNC_TOL, RST_BROAD_CLKS, RST_BROAD_TOL};
        cfg = nominal;
        seek_again();
        lead_time = '0;
        std_found = STD_UNKNOWN;
        std_shown = STD_UNKNOWN;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edges around the timer wrap, nominal timing
        tnow = 16'hFFF0;
        put(EDGE_TRAIL, tnow);                          // trailing before any leading
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_EQU_CLKS);           // wraps past zero
        tnow = tnow + (RST_LINE_CLKS >> 1);
        put(EDGE_LEAD, tnow);                           // half line: pre-equalise
        put(EDGE_TRAIL, tnow + RST_BROAD_CLKS);
        tnow = tnow + RST_LINE_CLKS;
        put(EDGE_LEAD, tnow);                           // full line too early: restart
        tnow = tnow + 16'd100;
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_HSYNC_CLKS);         // hsync outside post-equalise
        tnow = tnow + 16'd3000;
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + 16'd100);                // pulse out of range
        tnow = tnow + 16'd3000;
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow);                          // zero width
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + 16'hFFFF);               // widest pulse
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_BROAD_CLKS + RST_BROAD_TOL);
        tnow = tnow + 16'hFFFF;
        put(EDGE_LEAD, tnow);                           // longest period
        tnow = tnow + 16'd1;
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_EQU_CLKS - RST_EQU_TOL);
        tnow = tnow + ((RST_LINE_CLKS - RST_LINE_TOL) >> 1);
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_EQU_CLKS + RST_EQU_TOL);
        tnow = tnow + ((RST_LINE_CLKS + RST_LINE_TOL) >> 1);
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_HSYNC_CLKS + RST_HSYNC_TOL);
        put(EDGE_LEAD, tnow);
        put(EDGE_TRAIL, tnow + RST_HSYNC_CLKS - RST_HSYNC_TOL);

        tnow = 16'($urandom_range(65535));
        run_random(500);
        settle();

        load_timing('{16'd6000, 16'd60, 16'd220, 16'd25, 16'd440, 16'd25, 16'd2500, 16'd50});
        calm = 1'b1;
        run_random(350);
        settle();
        calm = 1'b0;

        load_timing('0);
        run_random(60);
        settle();

        load_timing('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_random(60);
        settle();

        // tolerances above nominal: lower bounds clamp at zero
        load_timing('{16'd300, 16'd400, 16'd10, 16'd30, 16'd40, 16'd50, 16'd120, 16'd200});
        run_random(150);
        settle();

        load_timing(nominal);
        run_random(250);
        settle();

        repeat (8) @(posedge i_clk);
        if (bad_n == 0 && status_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
